@@ hw/rtl/mur64_pkg.sv @@
// Shared types, constants and helpers for the MurmurHash64A stream hasher.
package mur64_pkg;

  // Mixing multiplier and shift of MurmurHash64A
  localparam logic [63:0] MurM = 64'hc6a4a7935bd1e995;
  localparam int unsigned MurR = 47;

  // Default width of the stated length and the byte counter
  localparam int unsigned LengthWidthDef = 32;

  // Packed widths of the stream payloads
  localparam int unsigned InDataW  = 104;  // 64 + 4 + 32 = 100, padded to bytes
  localparam int unsigned OutDataW = 64;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_APPLY
  } state_e;

  // What the datapath does with the product once it is ready
  typedef enum logic [2:0] {
    OP_INIT,
    OP_K1,
    OP_K2,
    OP_H,
    OP_FIN
  } op_e;

  // Source of the multiplier operand register
  typedef enum logic [2:0] {
    X_HOLD,
    X_LEN,
    X_WORD,
    X_MIX,
    X_FOLD,
    X_TAIL,
    X_FIN
  } xsel_e;

  // Source of the hash accumulator
  typedef enum logic [1:0] {
    H_HOLD,
    H_INIT,
    H_PROD
  } hsel_e;

  // Controller to datapath
  typedef struct packed {
    logic  accept;    // input beat taken this cycle
    logic  start;     // beat opens a new message
    xsel_e x_sel;
    hsel_e h_sel;
    logic  res_load;  // capture final hash into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_blk;   // live beat is mixed as a full block
    logic in_tail;  // live beat is a 1..7 byte tail
    logic in_last;
    logic q_blk;    // same, for the stored beat
    logic q_tail;
    logic q_last;
  } dp_sts_t;

  // Valid byte count limited to eight
  function automatic logic [3:0] clamp_vb(input logic [3:0] vb);
    clamp_vb = vb[3] ? 4'd8 : vb;
  endfunction

  // Keep the bytes below the valid count
  function automatic logic [63:0] tail_mask(input logic [3:0] vb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < vb) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    tail_mask = m;
  endfunction

endpackage

@@ hw/rtl/mur64_mul.sv @@
// Two-stage 64-bit low-half multiply by the MurmurHash64A constant.
module mur64_mul (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  output logic [63:0] prod_o
);

  localparam logic [31:0] MLo = mur64_pkg::MurM[31:0];
  localparam logic [31:0] MHi = mur64_pkg::MurM[63:32];

  logic [63:0] p0_q;
  logic [31:0] p1_q, p2_q;
  logic [63:0] prod_q, prod_d;

  // Stage 1: three 32x32 partial products, only low halves of the cross terms matter
  always_ff @(posedge clk_i) begin
    p0_q <= a_i[31:0] * MLo;
    p1_q <= 32'(a_i[63:32] * MLo);
    p2_q <= 32'(a_i[31:0] * MHi);
  end

  // Stage 2: fold the cross terms into the upper word
  assign prod_d = p0_q + {p1_q + p2_q, 32'd0};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ hw/rtl/mur64_dp.sv @@
// Datapath: beat capture, byte counting, hash accumulator and result register.
module mur64_dp #(
  parameter int unsigned LENGTH_WIDTH = mur64_pkg::LengthWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mur64_pkg::dp_cmd_t   cmd_i,
  output mur64_pkg::dp_sts_t   sts_o,
  input  logic                 cfg_we_i,
  input  logic [63:0]          cfg_data_i,
  input  logic [63:0]          data_word_i,
  input  logic [3:0]           valid_bytes_i,
  input  logic [31:0]          message_length_i,
  input  logic                 last_word_i,
  output logic [63:0]          hash_value_o,
  output logic                 length_error_o
);

  localparam int unsigned LenInW = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;

  logic [63:0]             seed_q, word_q, x_q, x_d, h_q, h_d, prod;
  logic [63:0]             hash_q, src_word;
  logic [3:0]              vb_q, vb_in, src_vb;
  logic                    last_q, err_q;
  logic [LENGTH_WIDTH-1:0] cnt_q, cnt_d, stated_q, len_in, cnt_add;

  mur64_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (x_q),
    .prod_o (prod)
  );

  // Live beat decode
  assign vb_in  = mur64_pkg::clamp_vb(valid_bytes_i);
  assign len_in = LENGTH_WIDTH'(message_length_i[LenInW-1:0]);

  assign sts_o.in_blk  = !last_word_i || vb_in[3];
  assign sts_o.in_tail = last_word_i && !vb_in[3] && (vb_in[2:0] != 3'd0);
  assign sts_o.in_last = last_word_i;
  assign sts_o.q_blk   = !last_q || vb_q[3];
  assign sts_o.q_tail  = last_q && !vb_q[3] && (vb_q[2:0] != 3'd0);
  assign sts_o.q_last  = last_q;

  // Word and count come straight from the bus in the accept cycle
  assign src_word = cmd_i.accept ? data_word_i : word_q;
  assign src_vb   = cmd_i.accept ? vb_in : vb_q;

  // Byte counter: a non-last beat always counts eight
  assign cnt_add = last_word_i ? LENGTH_WIDTH'(vb_in) : LENGTH_WIDTH'(4'd8);
  assign cnt_d   = (cmd_i.start ? '0 : cnt_q) + cnt_add;

  // Accumulator source
  always_comb begin
    case (cmd_i.h_sel)
      mur64_pkg::H_INIT: h_d = seed_q ^ prod;
      mur64_pkg::H_PROD: h_d = prod;
      default:           h_d = h_q;
    endcase
  end

  // Multiplier operand source
  always_comb begin
    case (cmd_i.x_sel)
      mur64_pkg::X_LEN:  x_d = 64'(len_in);
      mur64_pkg::X_WORD: x_d = src_word;
      mur64_pkg::X_MIX:  x_d = prod ^ (prod >> mur64_pkg::MurR);
      mur64_pkg::X_FOLD: x_d = h_q ^ prod;
      mur64_pkg::X_TAIL: x_d = h_d ^ (src_word & mur64_pkg::tail_mask(src_vb));
      mur64_pkg::X_FIN:  x_d = h_d ^ (h_d >> mur64_pkg::MurR);
      default:           x_d = x_q;
    endcase
  end

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_data_i;
    end
  end

  // Beat capture and length bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q <= data_word_i;
      vb_q   <= vb_in;
      last_q <= last_word_i;
      cnt_q  <= cnt_d;
      if (cmd_i.start) begin
        stated_q <= len_in;
      end
    end
  end

  // Hash state and multiplier operand
  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    x_q <= x_d;
  end

  // Result register: last avalanche step and length check
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      hash_q <= prod ^ (prod >> mur64_pkg::MurR);
      err_q  <= (cnt_q != stated_q);
    end
  end

  assign hash_value_o   = hash_q;
  assign length_error_o = err_q;

endmodule

@@ hw/rtl/mur64_ctrl.sv @@
// Controller: sequences the multiply steps of each beat and owns the handshakes.
module mur64_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mur64_pkg::dp_sts_t sts_i,
  output mur64_pkg::dp_cmd_t cmd_o
);

  mur64_pkg::state_e state_q, state_d;
  mur64_pkg::op_e    op_q, op_d;
  logic              in_msg_q, in_msg_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, out_free;

  assign accept   = (state_q == mur64_pkg::ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    in_msg_d    = in_msg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      mur64_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = mur64_pkg::ST_MUL0;
          in_msg_d = !sts_i.in_last;
          if (!in_msg_q)          op_d = mur64_pkg::OP_INIT;
          else if (sts_i.in_blk)  op_d = mur64_pkg::OP_K1;
          else if (sts_i.in_tail) op_d = mur64_pkg::OP_H;
          else                    op_d = mur64_pkg::OP_FIN;
        end
      end
      mur64_pkg::ST_MUL0: state_d = mur64_pkg::ST_MUL1;
      mur64_pkg::ST_MUL1: state_d = mur64_pkg::ST_APPLY;
      mur64_pkg::ST_APPLY: begin
        unique case (op_q)
          mur64_pkg::OP_INIT: begin
            state_d = mur64_pkg::ST_MUL0;
            if (sts_i.q_blk)       op_d = mur64_pkg::OP_K1;
            else if (sts_i.q_tail) op_d = mur64_pkg::OP_H;
            else                   op_d = mur64_pkg::OP_FIN;
          end
          mur64_pkg::OP_K1: begin
            state_d = mur64_pkg::ST_MUL0;
            op_d    = mur64_pkg::OP_K2;
          end
          mur64_pkg::OP_K2: begin
            state_d = mur64_pkg::ST_MUL0;
            op_d    = mur64_pkg::OP_H;
          end
          mur64_pkg::OP_H: begin
            if (sts_i.q_last) begin
              state_d = mur64_pkg::ST_MUL0;
              op_d    = mur64_pkg::OP_FIN;
            end else begin
              state_d = mur64_pkg::ST_IDLE;
            end
          end
          mur64_pkg::OP_FIN: begin
            // wait for the output register to drain
            if (out_free) begin
              state_d     = mur64_pkg::ST_IDLE;
              out_valid_d = 1'b1;
            end
          end
          default: state_d = mur64_pkg::ST_IDLE;
        endcase
      end
      default: state_d = mur64_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.x_sel    = mur64_pkg::X_HOLD;
    cmd_o.h_sel    = mur64_pkg::H_HOLD;
    cmd_o.accept   = accept;
    cmd_o.start    = accept && !in_msg_q;
    unique case (state_q)
      mur64_pkg::ST_IDLE: begin
        if (!in_msg_q)          cmd_o.x_sel = mur64_pkg::X_LEN;
        else if (sts_i.in_blk)  cmd_o.x_sel = mur64_pkg::X_WORD;
        else if (sts_i.in_tail) cmd_o.x_sel = mur64_pkg::X_TAIL;
        else                    cmd_o.x_sel = mur64_pkg::X_FIN;
      end
      mur64_pkg::ST_APPLY: begin
        unique case (op_q)
          mur64_pkg::OP_INIT: begin
            cmd_o.h_sel = mur64_pkg::H_INIT;
            if (sts_i.q_blk)       cmd_o.x_sel = mur64_pkg::X_WORD;
            else if (sts_i.q_tail) cmd_o.x_sel = mur64_pkg::X_TAIL;
            else                   cmd_o.x_sel = mur64_pkg::X_FIN;
          end
          mur64_pkg::OP_K1: cmd_o.x_sel = mur64_pkg::X_MIX;
          mur64_pkg::OP_K2: cmd_o.x_sel = mur64_pkg::X_FOLD;
          mur64_pkg::OP_H: begin
            cmd_o.h_sel = mur64_pkg::H_PROD;
            cmd_o.x_sel = mur64_pkg::X_FIN;
          end
          mur64_pkg::OP_FIN: cmd_o.res_load = out_free;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mur64_pkg::ST_IDLE;
      op_q        <= mur64_pkg::OP_INIT;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == mur64_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/murmur64a_stream_hash.sv @@
// Top level of the MurmurHash64A stream hasher.
// MurmurHash64A over a message streamed as little-endian 64-bit words, one
// beat per word; the first beat of a message carries the total byte length,
// a beat with tlast closes it and yields one hash beat, whose tuser bit flags
// a mismatch between counted and stated bytes. All 64-bit multiplies run on
// one two-stage multiplier by the constant; each multiply runs through both
// stages and then the step that uses the product. No new beat is taken until
// all multiplies of the current beat are done: 3 for a full word, plus 1 on
// the first word of a message (length times constant), 1 for a 1 to 7 byte
// tail, and 1 for the final avalanche. A finished hash waits in an output
// register while the next message is already being taken in. The seed
// register is read when a message starts; write it only between messages.
module murmur64a_stream_hash #(
  parameter int unsigned LENGTH_WIDTH = mur64_pkg::LengthWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // seed register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [63:0]                   cfg_data_i,
  // input words
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // data_word [63:0], valid_bytes [67:64], message_length [99:68], zero pad
  input  logic [mur64_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  // hash results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // hash_value [63:0]
  output logic [mur64_pkg::OutDataW-1:0] m_axis_tdata_o,
  // length_error [0]
  output logic                          m_axis_tuser_o
);

  mur64_pkg::dp_cmd_t cmd;
  mur64_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mur64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mur64_dp #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .data_word_i      (s_axis_tdata_i[63:0]),
    .valid_bytes_i    (s_axis_tdata_i[67:64]),
    .message_length_i (s_axis_tdata_i[99:68]),
    .last_word_i      (s_axis_tlast_i),
    .hash_value_o     (m_axis_tdata_o),
    .length_error_o   (m_axis_tuser_o)
  );

endmodule

@@ hw/rtl/mur64_chk.sv @@
// Port-level checker for the MurmurHash64A stream hasher, bound to the top level.
module mur64_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // Every input beat costs at least one multiply: the input is not ready while it runs
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=>
      !s_axis_tready_o ##1 !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input taken during a multiply");

  // A new result is only loaded by the finishing step, never while idle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without processing");

  // A fresh result is loaded only once the previous one has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i && !s_axis_tready_o |=>
      $stable(m_axis_tdata_o))
    else $error("pending result overwritten");

endmodule

bind murmur64a_stream_hash mur64_chk u_mur64_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
